>>> hdl/lwes_pkg.sv
// Shared types and constants for the lattice walker exclusion step block.
package lwes_pkg;

	// Fixed field widths of the stream and register interfaces
	localparam int WALKER_W = 10;
	localparam int COORD_W  = 9;
	localparam int DIR_W    = 2;
	localparam int GRID_W   = 10;
	localparam int COUNT_W  = 11;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 48;

	// Register reset values
	localparam logic [GRID_W-1:0]  GRID_WIDTH_RST   = 10'd300;
	localparam logic [GRID_W-1:0]  GRID_HEIGHT_RST  = 10'd300;
	localparam logic [COUNT_W-1:0] WALKER_COUNT_RST = 11'd900;

	// Register index, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_GRID_WIDTH   = 2'd0,
		REG_GRID_HEIGHT  = 2'd1,
		REG_WALKER_COUNT = 2'd2
	} reg_idx_t;

	// Request kind carried on tuser
	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_STEP = 1'b1
	} kind_t;

	// Step direction
	typedef enum logic [DIR_W-1:0] {
		DIR_RIGHT = 2'd0,
		DIR_UP    = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_DOWN  = 2'd3
	} dir_t;

	// Configuration handed from the register file to the core
	typedef struct packed {
		logic [GRID_W-1:0]  grid_width;
		logic [GRID_W-1:0]  grid_height;
		logic [COUNT_W-1:0] walker_count;
	} cfg_t;

endpackage

>>> hdl/lwes_regs.sv
// APB register file holding grid size and walker count.
module lwes_regs
	import lwes_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	// Write the addressed register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_width   <= GRID_WIDTH_RST;
			cfg_q.grid_height  <= GRID_HEIGHT_RST;
			cfg_q.walker_count <= WALKER_COUNT_RST;
		end else if (wr_en) begin
			case (idx)
				REG_GRID_WIDTH:   cfg_q.grid_width   <= pwdata[GRID_W-1:0];
				REG_GRID_HEIGHT:  cfg_q.grid_height  <= pwdata[GRID_W-1:0];
				REG_WALKER_COUNT: cfg_q.walker_count <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Return the addressed register, zero elsewhere
	always_comb begin
		prdata = '0;
		case (idx)
			REG_GRID_WIDTH:   prdata = PDATA_W'(cfg_q.grid_width);
			REG_GRID_HEIGHT:  prdata = PDATA_W'(cfg_q.grid_height);
			REG_WALKER_COUNT: prdata = PDATA_W'(cfg_q.walker_count);
			default:          prdata = '0;
		endcase
	end

endmodule

>>> hdl/lattice_walker_exclusion_step_core.sv
// Top level: walker position memory, step sequencer and occupancy scan.
//
//  channel | dir | handshake            | contents
//  s_*     | in  | s_tvalid / s_tready  | tuser kind; tdata walker, direction, load_x, load_y
//  m_*     | out | m_tvalid / m_tready  | tdata walker_index, old/new x,y, moved
//  apb     | in  | psel & penable       | grid_width @0, grid_height @4, walker_count @8
//
// A load writes the position to memory as the request is accepted.
// A step is paced by the occupancy scan, which reads one stored position per cycle from the
// single read port over min(walker_count, MAX_WALKERS) entries; an empty scan is skipped.
// Reset clears the sequencer and output registers only; positions are valid once loaded.
// A finished result waits in the output register; the next request is still taken.
module lattice_walker_exclusion_step_core
	import lwes_pkg::*;
#(
	parameter int MAX_WALKERS = 1024,
	parameter int COORD_BITS  = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// APB configuration
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready,
	// Request stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [9:0] walker, [11:10] direction, [20:12] load_x, [29:21] load_y, [31:30] zero
	input  logic [S_TDATA_W-1:0] s_tdata,
	// [0] kind
	input  logic                 s_tuser,
	// Result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [9:0] walker_index, [18:10] old_x, [27:19] old_y, [36:28] new_x,
	// [45:37] new_y, [46] moved, [47] zero
	output logic [M_TDATA_W-1:0] m_tdata
);

	localparam int AW   = (MAX_WALKERS > 1) ? $clog2(MAX_WALKERS) : 1;
	localparam int CW   = $clog2(MAX_WALKERS + 1);
	localparam int WCW  = (CW > COUNT_W) ? CW : COUNT_W;
	localparam int SZW  = (COORD_BITS + 1 > GRID_W) ? COORD_BITS + 1 : GRID_W;
	localparam int MW   = 2 * COORD_BITS;
	localparam logic [SZW-1:0] SIZE_MIN = SZW'(2);
	localparam logic [SZW-1:0] SIZE_TOP = SZW'(1) << COORD_BITS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OWN,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	cfg_t cfg;

	lwes_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Unpack the request
	logic [WALKER_W-1:0] in_walker;
	dir_t                in_dir;
	logic [COORD_W-1:0]  in_x;
	logic [COORD_W-1:0]  in_y;
	kind_t               in_kind;
	logic                in_ok;
	logic                s_acc;

	assign in_walker = s_tdata[9:0];
	assign in_dir    = dir_t'(s_tdata[11:10]);
	assign in_x      = s_tdata[20:12];
	assign in_y      = s_tdata[29:21];
	assign in_kind   = kind_t'(s_tuser);
	assign in_ok     = 32'(in_walker) < MAX_WALKERS;

	// Clamp the wrap points and the scan length
	function automatic logic [SZW-1:0] clamp_size(input logic [GRID_W-1:0] v);
		logic [SZW-1:0] e;
		e = SZW'(v);
		if (e < SIZE_MIN) return SIZE_MIN;
		if (e > SIZE_TOP) return SIZE_TOP;
		return e;
	endfunction

	logic [SZW-1:0] w_size;
	logic [SZW-1:0] h_size;
	logic [WCW-1:0] count_ext;
	logic [CW-1:0]  count;

	assign w_size    = clamp_size(cfg.grid_width);
	assign h_size    = clamp_size(cfg.grid_height);
	assign count_ext = WCW'(cfg.walker_count);
	assign count     = (count_ext > WCW'(MAX_WALKERS)) ? CW'(MAX_WALKERS) : CW'(count_ext);

	// Sequencer registers
	state_t                state_q;
	logic [AW-1:0]         w_q;
	dir_t                  dir_q;
	logic [COORD_BITS-1:0] ox_q;
	logic [COORD_BITS-1:0] oy_q;
	logic [MW-1:0]         tgt_q;
	logic [CW-1:0]         k_q;
	logic                  blocked_q;
	logic                  cmp_v_s1;
	logic                  m_tvalid_q;
	logic [M_TDATA_W-1:0]  m_tdata_q;

	// Memory ports
	logic [MW-1:0] mem [MAX_WALKERS];
	logic [AW-1:0] rd_addr;
	logic [MW-1:0] rd_data_s1;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [MW-1:0] wr_data;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;

	// Own position as read back from memory
	logic [COORD_BITS-1:0] rx;
	logic [COORD_BITS-1:0] ry;
	assign rx = rd_data_s1[COORD_BITS-1:0];
	assign ry = rd_data_s1[MW-1:COORD_BITS];

	// Target cell with periodic wrap
	function automatic logic [COORD_BITS-1:0] inc_wrap(input logic [COORD_BITS-1:0] v,
			input logic [SZW-1:0] size);
		logic [SZW-1:0] n;
		n = SZW'(v) + SZW'(1);
		return (n >= size) ? '0 : COORD_BITS'(n);
	endfunction

	function automatic logic [COORD_BITS-1:0] dec_wrap(input logic [COORD_BITS-1:0] v,
			input logic [SZW-1:0] size);
		logic [SZW-1:0] n;
		n = size - SZW'(1);
		return (v == '0) ? COORD_BITS'(n) : v - COORD_BITS'(1);
	endfunction

	logic [COORD_BITS-1:0] tx;
	logic [COORD_BITS-1:0] ty;

	always_comb begin
		tx = rx;
		ty = ry;
		case (dir_q)
			DIR_RIGHT: tx = inc_wrap(rx, w_size);
			DIR_UP:    ty = inc_wrap(ry, h_size);
			DIR_LEFT:  tx = dec_wrap(rx, w_size);
			DIR_DOWN:  ty = dec_wrap(ry, h_size);
			default:   tx = rx;
		endcase
	end

	// Memory address and write selection: loads in idle, moves at completion
	always_comb begin
		rd_addr = (state_q == ST_IDLE) ? AW'(in_walker) : k_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = w_q;
		wr_data = tgt_q;
		if (state_q == ST_IDLE) begin
			wr_en   = s_acc && (in_kind == KIND_LOAD) && in_ok;
			wr_addr = AW'(in_walker);
			wr_data = {COORD_BITS'(in_y), COORD_BITS'(in_x)};
		end else if (state_q == ST_DONE) begin
			wr_en = out_free && !blocked_q;
		end
	end

	// Position memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	// Step sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cmp_v_s1   <= 1'b0;
			blocked_q  <= 1'b0;
			k_q        <= '0;
			m_tvalid_q <= 1'b0;
			w_q        <= '0;
			dir_q      <= DIR_RIGHT;
			ox_q       <= '0;
			oy_q       <= '0;
			tgt_q      <= '0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			cmp_v_s1 <= (state_q == ST_SCAN);
			// Accumulate occupancy over the scanned entries
			if (cmp_v_s1 && (rd_data_s1 == tgt_q)) begin
				blocked_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc && (in_kind == KIND_STEP) && in_ok) begin
						w_q     <= AW'(in_walker);
						dir_q   <= in_dir;
						state_q <= ST_OWN;
					end
				end
				ST_OWN: begin
					ox_q      <= rx;
					oy_q      <= ry;
					tgt_q     <= {ty, tx};
					blocked_q <= 1'b0;
					k_q       <= '0;
					state_q   <= (count == '0) ? ST_DONE : ST_SCAN;
				end
				ST_SCAN: begin
					k_q <= k_q + CW'(1);
					if (k_q + CW'(1) == count) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// Hold until the output register is free, then report
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {1'b0,
							!blocked_q,
							blocked_q ? COORD_W'(oy_q) : COORD_W'(tgt_q[MW-1:COORD_BITS]),
							blocked_q ? COORD_W'(ox_q) : COORD_W'(tgt_q[COORD_BITS-1:0]),
							COORD_W'(oy_q),
							COORD_W'(ox_q),
							WALKER_W'(w_q)};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> tb/walker_step_checker.sv
// Checker: tracks walker positions and registers, predicts each step and compares results.
module walker_step_checker
	import lwes_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic                 pready,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	input  logic [PDATA_W-1:0]   prdata,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic                 s_tuser,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,
	output int                   errors,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WALKERS = 1024;

	typedef struct packed {
		logic [WALKER_W-1:0] walker;
		logic [COORD_W-1:0]  old_x;
		logic [COORD_W-1:0]  old_y;
		logic [COORD_W-1:0]  new_x;
		logic [COORD_W-1:0]  new_y;
		logic                moved;
	} move_t;

	logic [COORD_W-1:0]  walker_x [WALKERS];
	logic [COORD_W-1:0]  walker_y [WALKERS];
	logic [GRID_W-1:0]   grid_width   = GRID_WIDTH_RST;
	logic [GRID_W-1:0]   grid_height  = GRID_HEIGHT_RST;
	logic [COUNT_W-1:0]  walker_count = WALKER_COUNT_RST;
	move_t               expected_moves [$];
	move_t               want;
	logic [WALKER_W-1:0] req_walker;
	logic [PDATA_W-1:0]  stored;
	int                  mismatches = 0;

	// Clamp a grid size to the range the coordinates can express
	function automatic int unsigned wrap_size(logic [GRID_W-1:0] size);
		if (size < 2)
			return 2;
		if (size > (1 << COORD_W))
			return 1 << COORD_W;
		return 32'(size);
	endfunction

	// Compute the target cell, scan for occupancy, move the walker if the cell is free
	function automatic move_t resolve_step(logic [WALKER_W-1:0] w, dir_t dir);
		int unsigned x_span, y_span, scan, cur_x, cur_y, to_x, to_y, k;
		logic        blocked;
		move_t       mv;
		x_span = wrap_size(grid_width);
		y_span = wrap_size(grid_height);
		scan = (walker_count > WALKERS) ? WALKERS : 32'(walker_count);
		cur_x = 32'(walker_x[w]);
		cur_y = 32'(walker_y[w]);
		to_x = cur_x;
		to_y = cur_y;
		case (dir)
			DIR_RIGHT: to_x = (cur_x + 1 >= x_span) ? 0 : cur_x + 1;
			DIR_UP:    to_y = (cur_y + 1 >= y_span) ? 0 : cur_y + 1;
			DIR_LEFT:  to_x = (cur_x == 0) ? x_span - 1 : cur_x - 1;
			DIR_DOWN:  to_y = (cur_y == 0) ? y_span - 1 : cur_y - 1;
			default: ;
		endcase
		blocked = 1'b0;
		for (k = 0; k < scan; k++) begin
			if (32'(walker_x[WALKER_W'(k)]) == to_x && 32'(walker_y[WALKER_W'(k)]) == to_y)
				blocked = 1'b1;
		end
		if (!blocked) begin
			walker_x[w] = COORD_W'(to_x);
			walker_y[w] = COORD_W'(to_y);
		end
		mv.walker = w;
		mv.old_x  = COORD_W'(cur_x);
		mv.old_y  = COORD_W'(cur_y);
		mv.new_x  = walker_x[w];
		mv.new_y  = walker_y[w];
		mv.moved  = !blocked;
		return mv;
	endfunction

	task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (act_val !== exp_val) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
				act_val);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width   = GRID_WIDTH_RST;
			grid_height  = GRID_HEIGHT_RST;
			walker_count = WALKER_COUNT_RST;
			expected_moves.delete();
			pending <= 0;
		end else begin
			// Compare an accepted result with the oldest predicted step
			if (m_tvalid && m_tready) begin
				if (expected_moves.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual walker %0d",
						$time, m_tdata[9:0]);
					mismatches++;
				end else begin
					want = expected_moves.pop_front();
					check_field("walker_index", 32'(want.walker), 32'(m_tdata[9:0]));
					check_field("old_x", 32'(want.old_x), 32'(m_tdata[18:10]));
					check_field("old_y", 32'(want.old_y), 32'(m_tdata[27:19]));
					check_field("new_x", 32'(want.new_x), 32'(m_tdata[36:28]));
					check_field("new_y", 32'(want.new_y), 32'(m_tdata[45:37]));
					check_field("moved", 32'(want.moved), 32'(m_tdata[46]));
				end
			end

			// Apply a load or predict a step on every accepted request
			if (s_tvalid && s_tready) begin
				req_walker = s_tdata[9:0];
				if (kind_t'(s_tuser) == KIND_LOAD) begin
					walker_x[req_walker] = s_tdata[20:12];
					walker_y[req_walker] = s_tdata[29:21];
				end else begin
					expected_moves.push_back(resolve_step(req_walker,
						dir_t'(s_tdata[11:10])));
				end
			end

			// Track register writes, check readback
			if (psel && penable && pready) begin
				stored = '0;
				case (reg_idx_t'(paddr[3:2]))
					REG_GRID_WIDTH: begin
						if (pwrite)
							grid_width = pwdata[GRID_W-1:0];
						stored = PDATA_W'(grid_width);
					end
					REG_GRID_HEIGHT: begin
						if (pwrite)
							grid_height = pwdata[GRID_W-1:0];
						stored = PDATA_W'(grid_height);
					end
					REG_WALKER_COUNT: begin
						if (pwrite)
							walker_count = pwdata[COUNT_W-1:0];
						stored = PDATA_W'(walker_count);
					end
					default: ;
				endcase
				if (!pwrite)
					check_field("prdata", stored, prdata);
			end

			pending <= expected_moves.size();
		end
		errors <= mismatches;
	end

endmodule

>>> tb/tb.sv
// Testbench top: clock, reset, request and register stimulus, result backpressure, verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lwes_pkg::*;

	// Walkers loaded up front; every scan and every mixed-traffic step stays inside them
	localparam int PRELOAD = 128;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 psel     = 1'b0;
	logic                 penable  = 1'b0;
	logic                 pwrite   = 1'b0;
	logic [PADDR_W-1:0]   paddr    = '0;
	logic [PDATA_W-1:0]   pwdata   = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// [9:0] walker, [11:10] direction, [20:12] load_x, [29:21] load_y, [31:30] zero
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	// [0] kind
	logic                 s_tuser  = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// [9:0] walker_index, [18:10] old_x, [27:19] old_y, [36:28] new_x,
	// [45:37] new_y, [46] moved, [47] zero
	logic [M_TDATA_W-1:0] m_tdata;
	int                   errors;
	int                   pending;

	int unsigned          cur_scan  = 900;
	logic                 s_steady  = 1'b0;

	lattice_walker_exclusion_step_core dut (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata
	);

	walker_step_checker u_checker (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata, .prdata,
		.s_tvalid, .s_tready, .s_tuser, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata,
		.errors, .pending
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Mostly short gaps, now and then a long one
	function automatic int unsigned idle_cycles();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(25, 80);
	endfunction

	// Coordinate mostly inside a small window, sometimes anywhere
	function automatic logic [COORD_W-1:0] near(int unsigned span);
		if ($urandom_range(0, 99) < 80)
			return COORD_W'($urandom_range(0, span - 1));
		return COORD_W'($urandom_range(0, 511));
	endfunction

	// Stall the result channel in random bursts
	initial begin : result_sink
		int unsigned burst;
		forever begin
			if ($urandom_range(0, 9) == 0)
				burst = $urandom_range(200, 400);
			else
				burst = $urandom_range(1, 30);
			m_tready <= 1'b1;
			repeat (burst) @(posedge clk);
			m_tready <= 1'b0;
			repeat (1 + idle_cycles()) @(posedge clk);
		end
	end

	// Present one request after an optional gap and hold it until accepted
	task automatic send_request(kind_t kind, logic [WALKER_W-1:0] w, dir_t dir,
			logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		int unsigned gap;
		gap = s_steady ? 0 : idle_cycles();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {2'b00, y, x, dir, w};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic load_walker(logic [WALKER_W-1:0] w, logic [COORD_W-1:0] x,
			logic [COORD_W-1:0] y);
		send_request(KIND_LOAD, w, dir_t'($urandom_range(0, 3)), x, y);
	endtask

	task automatic step_walker(logic [WALKER_W-1:0] w, dir_t dir);
		send_request(KIND_STEP, w, dir, COORD_W'($urandom), COORD_W'($urandom));
	endtask

	// One APB access: setup cycle, then access cycle; bus stays selected afterwards
	task automatic apb_access(logic wr, reg_idx_t idx, logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
	endtask

	// Drop valid, wait for every outstanding step, then let the scan finish
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (cur_scan + 8) @(posedge clk);
	endtask

	// Pull a crowd of scanned walkers together, then mix loads and steps
	task automatic mixed_traffic(int unsigned n, int unsigned span);
		int unsigned crowd, w, i;
		crowd = (cur_scan < 24) ? cur_scan : 24;
		for (i = 0; i < crowd; i++)
			load_walker(WALKER_W'(i), near(span), near(span));
		for (i = 0; i < n; i++) begin
			if (crowd != 0 && $urandom_range(0, 99) < 70)
				w = $urandom_range(0, crowd - 1);
			else
				w = $urandom_range(0, PRELOAD - 1);
			if ($urandom_range(0, 99) < 65)
				step_walker(WALKER_W'(w), dir_t'($urandom_range(0, 3)));
			else
				load_walker(WALKER_W'(w), near(span), near(span));
		end
	endtask

	task automatic run_phase(logic [GRID_W-1:0] width, logic [GRID_W-1:0] height,
			logic [COUNT_W-1:0] count, int unsigned n, int unsigned span);
		settle();
		apb_access(1'b1, REG_GRID_WIDTH, {22'($urandom), width});
		apb_access(1'b1, REG_GRID_HEIGHT, {22'($urandom), height});
		apb_access(1'b1, REG_WALKER_COUNT, {21'($urandom), count});
		apb_access(1'b0, REG_GRID_WIDTH, '0);
		apb_access(1'b0, REG_GRID_HEIGHT, '0);
		apb_access(1'b0, REG_WALKER_COUNT, '0);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		cur_scan = (count > 1024) ? 1024 : 32'(count);
		s_steady = ($urandom_range(0, 3) == 0);
		mixed_traffic(n, span);
	endtask

	initial begin : stimulus
		int unsigned i;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Narrow the scan so that it covers only the preloaded walkers
		apb_access(1'b1, REG_WALKER_COUNT, 32'(PRELOAD - 32));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		cur_scan = PRELOAD - 32;

		// Give every walker a scan or a step can read a position first
		for (i = 0; i < PRELOAD; i++)
			load_walker(WALKER_W'(i), COORD_W'($urandom), COORD_W'($urandom));

		// Wrap from zero to the far edge
		load_walker(10'd0, 9'd0, 9'd0);
		step_walker(10'd0, DIR_LEFT);
		step_walker(10'd0, DIR_DOWN);
		// Step right or up from beyond the wrap point lands on zero
		load_walker(10'd1023, 9'd511, 9'd511);
		step_walker(10'd1023, DIR_RIGHT);
		step_walker(10'd1023, DIR_UP);
		// Step left or down from beyond the wrap point just subtracts one
		load_walker(10'd7, 9'd511, 9'd400);
		step_walker(10'd7, DIR_LEFT);
		step_walker(10'd7, DIR_DOWN);
		// Two neighbors block each other, then one steps aside
		load_walker(10'd1, 9'd10, 9'd10);
		load_walker(10'd2, 9'd11, 9'd10);
		step_walker(10'd1, DIR_RIGHT);
		step_walker(10'd2, DIR_LEFT);
		step_walker(10'd2, DIR_UP);
		step_walker(10'd1, DIR_DOWN);
		// Walk onto the last column, then wrap
		load_walker(10'd3, 9'd298, 9'd5);
		step_walker(10'd3, DIR_RIGHT);
		step_walker(10'd3, DIR_RIGHT);
		step_walker(10'd3, DIR_UP);
		// A walker outside the scanned range does not block
		load_walker(10'd950, 9'd20, 9'd20);
		load_walker(10'd4, 9'd19, 9'd20);
		step_walker(10'd4, DIR_RIGHT);

		mixed_traffic(30, 24);
		// Crowded 2x2 torus: most steps are blocked
		run_phase(10'd2, 10'd2, 11'd4, 60, 3);
		// Sizes below the minimum act as 2; an empty scan never blocks
		run_phase(10'd0, 10'd1, 11'd0, 50, 4);
		run_phase(10'd5, 10'd3, 11'd12, 60, 7);
		// Oversized sizes clamp to the coordinate range
		run_phase(10'd1023, 10'd1023, 11'd120, 25, 6);
		run_phase(10'd512, 10'd512, 11'd128, 25, 6);
		repeat (2)
			run_phase(10'($urandom_range(2, 16)), 10'($urandom_range(2, 16)),
				11'($urandom_range(1, 40)), 35, 18);

		settle();
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> files.f
hdl/lwes_pkg.sv
hdl/lwes_regs.sv
hdl/lattice_walker_exclusion_step_core.sv
tb/walker_step_checker.sv
tb/tb.sv
